>>> design/ray_segment_intersect_assert.svh
// Assertion helpers shared by the ray/segment intersection RTL.
`ifndef RAY_SEGMENT_INTERSECT_ASSERT_SVH
`define RAY_SEGMENT_INTERSECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rsi_pkg.sv
package rsi_pkg;

  // Result field widths are fixed by the output format.
  localparam int DIST_BITS = 34;
  localparam int POS_BITS  = 32;

  typedef logic [DIST_BITS-1:0]       dist_t;
  typedef logic signed [POS_BITS-1:0] pos_t;

  // Control that travels along with every slot of the cell chains.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } rsi_ctl_t;

endpackage

>>> design/rsi_ray_if.sv
interface rsi_ray_if #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;

  modport source (
    output valid, origin_x, origin_y, dir_x, dir_y,
    output seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, dir_x, dir_y,
    input  seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

>>> design/rsi_hit_if.sv
interface rsi_hit_if ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  rsi_pkg::dist_t       distance;
  rsi_pkg::pos_t        hit_x;
  rsi_pkg::pos_t        hit_y;

  modport source (output valid, hit, distance, hit_x, hit_y, input ready);
  modport sink   (input valid, hit, distance, hit_x, hit_y, output ready);
endinterface

>>> design/rsi_div_cell.sv
// One restoring-division step for the x and y lanes: one quotient bit each.
module rsi_div_cell #(
  parameter int DW  = 51,
  parameter int QW  = 33,
  parameter int SBW = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  rsi_pkg::rsi_ctl_t        ctl_i,
  input  logic [DW-1:0]            det_i,
  input  logic [1:0][DW-1:0]       rem_i,
  input  logic [1:0][QW-1:0]       nq_i,
  input  logic [SBW-1:0]           sb_i,
  output rsi_pkg::rsi_ctl_t        ctl_o,
  output logic [DW-1:0]            det_o,
  output logic [1:0][DW-1:0]       rem_o,
  output logic [1:0][QW-1:0]       nq_o,
  output logic [SBW-1:0]           sb_o
);
  import rsi_pkg::*;

  rsi_ctl_t            ctl_q;
  logic [DW-1:0]       det_q;
  logic [1:0][DW-1:0]  rem_d, rem_q;
  logic [1:0][QW-1:0]  nq_d, nq_q;
  logic [SBW-1:0]      sb_q;

  // Shift in the next dividend bit, subtract when it fits
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DW:0]   shl;
    logic [DW+1:0] dif;
    logic          take;
    assign shl  = {rem_i[l], nq_i[l][QW-1]};
    assign dif  = {1'b0, shl} - {2'b00, det_i};
    assign take = !dif[DW+1];
    assign rem_d[l] = take ? dif[DW-1:0] : shl[DW-1:0];
    assign nq_d[l]  = {nq_i[l][QW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= det_i;
      rem_q <= rem_d;
      nq_q  <= nq_d;
      sb_q  <= sb_i;
    end
  end

  assign ctl_o = ctl_q;
  assign det_o = det_q;
  assign rem_o = rem_q;
  assign nq_o  = nq_q;
  assign sb_o  = sb_q;

endmodule

>>> design/rsi_sqrt_cell.sv
// One digit-by-digit square root step: one root bit per cell.
module rsi_sqrt_cell #(
  parameter int SW  = 34,
  parameter int SBW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rsi_pkg::rsi_ctl_t ctl_i,
  input  logic [SW+1:0]     rem_i,
  input  logic [SW-1:0]     root_i,
  input  logic [2*SW-1:0]   xr_i,
  input  logic [SBW-1:0]    sb_i,
  output rsi_pkg::rsi_ctl_t ctl_o,
  output logic [SW+1:0]     rem_o,
  output logic [SW-1:0]     root_o,
  output logic [2*SW-1:0]   xr_o,
  output logic [SBW-1:0]    sb_o
);
  import rsi_pkg::*;

  rsi_ctl_t          ctl_q;
  logic [SW+1:0]     rem_d, rem_q;
  logic [SW-1:0]     root_d, root_q;
  logic [2*SW-1:0]   xr_q;
  logic [SBW-1:0]    sb_q;
  logic [SW+3:0]     shl;
  logic [SW+4:0]     dif;
  logic              take;

  // Bring down two radicand bits, try root*4+1
  assign shl    = {rem_i, xr_i[2*SW-1 -: 2]};
  assign dif    = {1'b0, shl} - {3'b000, root_i, 2'b01};
  assign take   = !dif[SW+4];
  assign rem_d  = take ? dif[SW+1:0] : shl[SW+1:0];
  assign root_d = {root_i[SW-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      xr_q   <= {xr_i[2*SW-3:0], 2'b00};
      sb_q   <= sb_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign xr_o   = xr_q;
  assign sb_o   = sb_q;

endmodule

>>> design/ray_segment_intersect.sv
// Channel | Dir | Payload
// ray_i   | in  | origin, direction, segment start and end (signed integers)
// res_o   | out | hit flag, distance (Q26.8), hit point x/y (Q24.8)
//
// One transaction per cycle in and out. The pipeline runs through a divider chain
// (one quotient bit per cell) and a square root chain (one root bit per cell).
// rst_ni clears every valid bit at once; the datapath is not reset.
// A result held at res_o with ready low freezes the whole pipeline and ray_i.ready.
`include "ray_segment_intersect_assert.svh"

module ray_segment_intersect #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsi_ray_if.sink    ray_i,
  rsi_hit_if.source  res_o
);
  import rsi_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int CW   = C + 1;
  localparam int PW   = 2 * CW;
  localparam int TW   = PW + 1;
  localparam int H    = (TW + 1) / 2;
  localparam int QW   = C + F + 1;
  localparam int NW   = C + TW + F;
  localparam int OW   = QW + 1;
  localparam int AW   = OW + 1;
  localparam int SW   = QW + 1;
  localparam int SQW  = 2 * QW;
  localparam int SATW = (AW > POS_BITS + 1) ? AW : POS_BITS + 1;
  localparam int EW   = (SW > DIST_BITS) ? SW : DIST_BITS;
  localparam int DSB  = 2 * C;
  localparam int QSB  = 2 * POS_BITS;

  localparam logic signed [SATW-1:0] POS_MAX = {{(SATW-POS_BITS){1'b0}}, 1'b0,
                                                {(POS_BITS-1){1'b1}}};
  localparam logic signed [SATW-1:0] POS_MIN = {{(SATW-POS_BITS){1'b1}}, 1'b1,
                                                {(POS_BITS-1){1'b0}}};
  localparam logic [EW-1:0] DIST_MAX = EW'({DIST_BITS{1'b1}});

  logic en;
  logic out_v_q;

  // Global advance: the pipeline moves unless a result is stuck at the port
  assign en          = !out_v_q || res_o.ready;
  assign ray_i.ready = en;

  // Stage 1: edge and offset vectors
  logic                  s1_v_q;
  logic signed [CW-1:0]  s1_fx_q, s1_fy_q, s1_ax_q, s1_ay_q, s1_dx_q, s1_dy_q;
  logic signed [C-1:0]   s1_vx_q, s1_vy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_fx_q <= {ray_i.seg_end_x[C-1], ray_i.seg_end_x}
               - {ray_i.seg_start_x[C-1], ray_i.seg_start_x};
      s1_fy_q <= {ray_i.seg_end_y[C-1], ray_i.seg_end_y}
               - {ray_i.seg_start_y[C-1], ray_i.seg_start_y};
      s1_ax_q <= {ray_i.seg_start_x[C-1], ray_i.seg_start_x}
               - {ray_i.origin_x[C-1], ray_i.origin_x};
      s1_ay_q <= {ray_i.seg_start_y[C-1], ray_i.seg_start_y}
               - {ray_i.origin_y[C-1], ray_i.origin_y};
      s1_dx_q <= {ray_i.dir_x[C-1], ray_i.dir_x};
      s1_dy_q <= {ray_i.dir_y[C-1], ray_i.dir_y};
      s1_vx_q <= ray_i.origin_x;
      s1_vy_q <= ray_i.origin_y;
    end
  end

  // Stage 2: the six cross products
  logic                     s2_v_q;
  logic signed [PW-1:0]     s2_p_d [6];
  logic signed [PW-1:0]     s2_p_q [6];
  logic signed [CW-1:0]     s2_dx_q, s2_dy_q;
  logic signed [C-1:0]      s2_vx_q, s2_vy_q;

  assign s2_p_d[0] = PW'(s1_dx_q) * PW'(s1_fy_q);
  assign s2_p_d[1] = PW'(s1_fx_q) * PW'(s1_dy_q);
  assign s2_p_d[2] = PW'(s1_dy_q) * PW'(s1_ax_q);
  assign s2_p_d[3] = PW'(s1_dx_q) * PW'(s1_ay_q);
  assign s2_p_d[4] = PW'(s1_fy_q) * PW'(s1_ax_q);
  assign s2_p_d[5] = PW'(s1_fx_q) * PW'(s1_ay_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_p_q  <= s2_p_d;
      s2_dx_q <= s1_dx_q;
      s2_dy_q <= s1_dy_q;
      s2_vx_q <= s1_vx_q;
      s2_vy_q <= s1_vy_q;
    end
  end

  // Stage 3: determinant and the two numerators
  logic                 s3_v_q;
  logic signed [TW-1:0] s3_det_q, s3_rn_q, s3_tn_q;
  logic signed [CW-1:0] s3_dx_q, s3_dy_q;
  logic signed [C-1:0]  s3_vx_q, s3_vy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_det_q <= TW'(s2_p_q[0]) - TW'(s2_p_q[1]);
      s3_rn_q  <= TW'(s2_p_q[2]) - TW'(s2_p_q[3]);
      s3_tn_q  <= TW'(s2_p_q[4]) - TW'(s2_p_q[5]);
      s3_dx_q  <= s2_dx_q;
      s3_dy_q  <= s2_dy_q;
      s3_vx_q  <= s2_vx_q;
      s3_vy_q  <= s2_vy_q;
    end
  end

  // Stage 4: make the determinant non-negative
  logic                 s4_v_q;
  logic signed [TW-1:0] s4_det_q, s4_rn_q, s4_tn_q;
  logic signed [CW-1:0] s4_dx_q, s4_dy_q;
  logic signed [C-1:0]  s4_vx_q, s4_vy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_det_q <= s3_det_q[TW-1] ? -s3_det_q : s3_det_q;
      s4_rn_q  <= s3_det_q[TW-1] ? -s3_rn_q  : s3_rn_q;
      s4_tn_q  <= s3_det_q[TW-1] ? -s3_tn_q  : s3_tn_q;
      s4_dx_q  <= s3_dx_q;
      s4_dy_q  <= s3_dy_q;
      s4_vx_q  <= s3_vx_q;
      s4_vy_q  <= s3_vy_q;
    end
  end

  // Stage 5: hit decision and split |d| * tn partial products
  rsi_ctl_t             s5_ctl_q;
  logic                 s5_hit_d;
  logic [CW-1:0]        adx_full, ady_full;
  logic [C-1:0]         adx, ady;
  logic [C+H-1:0]       s5_pxl_q, s5_pyl_q;
  logic [C+TW-H-1:0]    s5_pxh_q, s5_pyh_q;
  logic [TW-1:0]        s5_det_q;
  logic signed [C-1:0]  s5_vx_q, s5_vy_q;

  assign s5_hit_d = (s4_det_q != '0) && !s4_rn_q[TW-1] && !s4_tn_q[TW-1]
                 && (s4_rn_q <= s4_det_q);
  assign adx_full = s4_dx_q[CW-1] ? -s4_dx_q : s4_dx_q;
  assign ady_full = s4_dy_q[CW-1] ? -s4_dy_q : s4_dy_q;
  assign adx      = adx_full[C-1:0];
  assign ady      = ady_full[C-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_pxl_q <= (C+H)'(adx) * (C+H)'(s4_tn_q[H-1:0]);
      s5_pxh_q <= (C+TW-H)'(adx) * (C+TW-H)'(s4_tn_q[TW-1:H]);
      s5_pyl_q <= (C+H)'(ady) * (C+H)'(s4_tn_q[H-1:0]);
      s5_pyh_q <= (C+TW-H)'(ady) * (C+TW-H)'(s4_tn_q[TW-1:H]);
      s5_det_q <= s4_det_q;
      s5_vx_q  <= s4_vx_q;
      s5_vy_q  <= s4_vy_q;
    end
  end

  // Valid bits of the front stages and the control word entering the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      s5_ctl_q <= '0;
    end else if (en) begin
      s1_v_q   <= ray_i.valid;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q;
      s4_v_q   <= s3_v_q;
      s5_ctl_q <= '{valid: s4_v_q, hit: s5_hit_d,
                    neg_x: s4_dx_q[CW-1], neg_y: s4_dy_q[CW-1]};
    end
  end

  // Dividend |d| * tn * 2^F, split into the starting remainder and low bits
  logic [C+TW-1:0] prod_x, prod_y;
  logic [NW-1:0]   num_x, num_y;

  assign prod_x = {s5_pxh_q, {H{1'b0}}} + (C+TW)'(s5_pxl_q);
  assign prod_y = {s5_pyh_q, {H{1'b0}}} + (C+TW)'(s5_pyl_q);
  assign num_x  = {prod_x, {F{1'b0}}};
  assign num_y  = {prod_y, {F{1'b0}}};

  // Divider chain: one quotient bit per cell
  rsi_ctl_t            div_ctl [QW+1];
  logic [TW-1:0]       div_det [QW+1];
  logic [1:0][TW-1:0]  div_rem [QW+1];
  logic [1:0][QW-1:0]  div_nq  [QW+1];
  logic [DSB-1:0]      div_sb  [QW+1];

  assign div_ctl[0]    = s5_ctl_q;
  assign div_det[0]    = s5_det_q;
  assign div_rem[0][0] = {1'b0, num_x[NW-1:QW]};
  assign div_rem[0][1] = {1'b0, num_y[NW-1:QW]};
  assign div_nq[0][0]  = num_x[QW-1:0];
  assign div_nq[0][1]  = num_y[QW-1:0];
  assign div_sb[0]     = {s5_vx_q, s5_vy_q};

  for (genvar i = 0; i < QW; i++) begin : g_div
    rsi_div_cell #(
      .DW  (TW),
      .QW  (QW),
      .SBW (DSB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (div_ctl[i]),
      .det_i  (div_det[i]),
      .rem_i  (div_rem[i]),
      .nq_i   (div_nq[i]),
      .sb_i   (div_sb[i]),
      .ctl_o  (div_ctl[i+1]),
      .det_o  (div_det[i+1]),
      .rem_o  (div_rem[i+1]),
      .nq_o   (div_nq[i+1]),
      .sb_o   (div_sb[i+1])
    );
  end

  // Stage 7: floor rounding and sign of the offsets
  rsi_ctl_t            s7_ctl_q;
  logic [QW-1:0]       mag_x, mag_y;
  logic [QW-1:0]       s7_mx_q, s7_my_q;
  logic signed [OW-1:0] s7_ox_q, s7_oy_q;
  logic signed [C-1:0] s7_vx_q, s7_vy_q;

  assign mag_x = div_nq[QW][0]
               + QW'(div_ctl[QW].neg_x && (div_rem[QW][0] != '0));
  assign mag_y = div_nq[QW][1]
               + QW'(div_ctl[QW].neg_y && (div_rem[QW][1] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_ctl_q <= '0;
    end else if (en) begin
      s7_ctl_q <= div_ctl[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_mx_q <= mag_x;
      s7_my_q <= mag_y;
      s7_ox_q <= div_ctl[QW].neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      s7_oy_q <= div_ctl[QW].neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      s7_vx_q <= div_sb[QW][DSB-1:C];
      s7_vy_q <= div_sb[QW][C-1:0];
    end
  end

  // Stage 8: hit point and squared offsets
  rsi_ctl_t            s8_ctl_q;
  logic signed [AW-1:0] s8_hx_q, s8_hy_q;
  logic [SQW-1:0]      s8_sx_q, s8_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_ctl_q <= '0;
    end else if (en) begin
      s8_ctl_q <= s7_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_hx_q <= AW'($signed({s7_vx_q, {F{1'b0}}})) + AW'(s7_ox_q);
      s8_hy_q <= AW'($signed({s7_vy_q, {F{1'b0}}})) + AW'(s7_oy_q);
      s8_sx_q <= SQW'(s7_mx_q) * SQW'(s7_mx_q);
      s8_sy_q <= SQW'(s7_my_q) * SQW'(s7_my_q);
    end
  end

  // Sum of squares and hit point saturation, feeding the root chain
  logic [SQW:0]          sq_sum;
  logic signed [SATW-1:0] hx_e, hy_e;
  pos_t                  hx_sat, hy_sat;

  assign sq_sum = (SQW+1)'(s8_sx_q) + (SQW+1)'(s8_sy_q);
  assign hx_e   = SATW'(s8_hx_q);
  assign hy_e   = SATW'(s8_hy_q);

  always_comb begin
    if (hx_e > POS_MAX) begin
      hx_sat = POS_MAX[POS_BITS-1:0];
    end else if (hx_e < POS_MIN) begin
      hx_sat = POS_MIN[POS_BITS-1:0];
    end else begin
      hx_sat = hx_e[POS_BITS-1:0];
    end
    if (hy_e > POS_MAX) begin
      hy_sat = POS_MAX[POS_BITS-1:0];
    end else if (hy_e < POS_MIN) begin
      hy_sat = POS_MIN[POS_BITS-1:0];
    end else begin
      hy_sat = hy_e[POS_BITS-1:0];
    end
  end

  // Square root chain: one root bit per cell
  rsi_ctl_t           sq_ctl  [SW+1];
  logic [SW+1:0]      sq_rem  [SW+1];
  logic [SW-1:0]      sq_root [SW+1];
  logic [2*SW-1:0]    sq_xr   [SW+1];
  logic [QSB-1:0]     sq_sb   [SW+1];

  assign sq_ctl[0]  = s8_ctl_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_xr[0]   = (2*SW)'(sq_sum);
  assign sq_sb[0]   = {hx_sat, hy_sat};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    rsi_sqrt_cell #(
      .SW  (SW),
      .SBW (QSB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .xr_i   (sq_xr[i]),
      .sb_i   (sq_sb[i]),
      .ctl_o  (sq_ctl[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .xr_o   (sq_xr[i+1]),
      .sb_o   (sq_sb[i+1])
    );
  end

  // Output register: distance saturation, zero fields on a miss
  logic [EW-1:0] root_e;
  dist_t         dist_sat;
  logic          out_hit_q;
  dist_t         out_dist_q;
  pos_t          out_hx_q, out_hy_q;

  assign root_e   = EW'(sq_root[SW]);
  assign dist_sat = (root_e > DIST_MAX) ? {DIST_BITS{1'b1}} : root_e[DIST_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= sq_ctl[SW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q  <= sq_ctl[SW].hit;
      out_dist_q <= sq_ctl[SW].hit ? dist_sat : '0;
      out_hx_q   <= sq_ctl[SW].hit ? sq_sb[SW][QSB-1:POS_BITS] : '0;
      out_hy_q   <= sq_ctl[SW].hit ? sq_sb[SW][POS_BITS-1:0] : '0;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.hit      = out_hit_q;
  assign res_o.distance = out_dist_q;
  assign res_o.hit_x    = out_hx_q;
  assign res_o.hit_y    = out_hy_q;

  // Checks
  `RSI_ASSERT_IMPLY(a_miss_fields_zero, clk_i, rst_ni, res_o.valid && !res_o.hit, (res_o.distance == '0) && (res_o.hit_x == '0) && (res_o.hit_y == '0), "miss result carries nonzero fields")
  `RSI_ASSERT_IMPLY(a_div_rem_bound, clk_i, rst_ni, div_ctl[QW].valid && div_ctl[QW].hit, (div_rem[QW][0] < div_det[QW]) && (div_rem[QW][1] < div_det[QW]), "division remainder not below divisor")
  `RSI_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, !en, $stable(div_ctl[QW]) && $stable(sq_ctl[SW]), "pipeline moved during a stall")

endmodule
